[rtl/two_digit_seven_segment_serial_driver_core_macros.svh]
// Assertion macros for the seven-segment serial driver.
`ifndef TWO_DIGIT_SEVEN_SEGMENT_SERIAL_DRIVER_CORE_MACROS_SVH
`define TWO_DIGIT_SEVEN_SEGMENT_SERIAL_DRIVER_CORE_MACROS_SVH

// Same-cycle implication.
`define SSD_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define SSD_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

[rtl/ssd_pkg.sv]
package ssd_pkg;

  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_SET_DEC = 2'd1;
  localparam logic [1:0] OP_SET_HEX = 2'd2;

  localparam int unsigned BEAT_CNT_W   = 5;
  localparam logic [BEAT_CNT_W-1:0] BLANK_STROBE = 5'd8;
  localparam logic [BEAT_CNT_W-1:0] PAT_FIRST    = 5'd9;
  localparam logic [BEAT_CNT_W-1:0] PAT_MSB_POS  = 5'd16;
  localparam logic [BEAT_CNT_W-1:0] LAST_BEAT    = 5'd17;

  localparam logic [6:0]  DEC_MAX   = 7'd99;
  localparam logic [13:0] DIV10_MUL = 14'd103;

  typedef struct packed {
    logic [7:0] pattern;
    logic       phase;
  } tick_t;

  // Segment order MSB..LSB: g c d e a b f dp
  function automatic logic [7:0] seg_lookup(input logic [3:0] nib);
    logic [7:0] seg;
    case (nib)
      4'h0: seg = 8'h7e;
      4'h1: seg = 8'h44;
      4'h2: seg = 8'hbc;
      4'h3: seg = 8'hec;
      4'h4: seg = 8'hc6;
      4'h5: seg = 8'hea;
      4'h6: seg = 8'hfa;
      4'h7: seg = 8'h4c;
      4'h8: seg = 8'hfe;
      4'h9: seg = 8'hee;
      4'ha: seg = 8'hde;
      4'hb: seg = 8'hf2;
      4'hc: seg = 8'h3a;
      4'hd: seg = 8'hf4;
      4'he: seg = 8'hba;
      default: seg = 8'h9a;
    endcase
    return seg;
  endfunction

endpackage

[rtl/ssd_front.sv]
module ssd_front import ssd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [1:0] op_i,
  input  logic [7:0] value_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output tick_t      q_data_o
);

  logic [7:0]  digit_q [2];
  logic [7:0]  digit0_d, digit1_d;
  logic        phase_q, phase_d;
  logic        accept;
  logic [6:0]  dec_val;
  logic [13:0] dec_prod;
  logic [3:0]  tens;
  logic [6:0]  ones_w;

  assign full   = q_full_i;
  assign accept = push && !q_full_i;

  assign dec_val  = (value_i > {1'b0, DEC_MAX}) ? DEC_MAX : value_i[6:0];
  assign dec_prod = {7'd0, dec_val} * DIV10_MUL;
  assign tens     = dec_prod[13:10];
  assign ones_w   = dec_val - ({3'd0, tens} * 7'd10);

  always_comb begin
    digit0_d = digit_q[0];
    digit1_d = digit_q[1];
    phase_d  = phase_q;
    q_push_o = 1'b0;
    if (accept) begin
      case (op_i)
        OP_TICK: begin
          phase_d  = ~phase_q;
          q_push_o = 1'b1;
        end
        OP_SET_DEC: begin
          digit0_d = seg_lookup(ones_w[3:0]);
          digit1_d = seg_lookup(tens);
        end
        OP_SET_HEX: begin
          digit0_d = seg_lookup(value_i[3:0]);
          digit1_d = seg_lookup(value_i[7:4]);
        end
        default: ;
      endcase
    end
  end

  assign q_data_o.phase   = ~phase_q;
  assign q_data_o.pattern = digit_q[~phase_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q[0] <= '0;
      digit_q[1] <= '0;
      phase_q    <= 1'b0;
    end else begin
      digit_q[0] <= digit0_d;
      digit_q[1] <= digit1_d;
      phase_q    <= phase_d;
    end
  end

endmodule

[rtl/ssd_queue.sv]
module ssd_queue import ssd_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  tick_t data_i,
  output logic  full_o,
  output logic  valid_o,
  input  logic  pop_i,
  output tick_t data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  tick_t            mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_FULL);
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

[rtl/ssd_back.sv]
module ssd_back import ssd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  common_anode_i,
  input  logic  q_valid_i,
  input  tick_t q_data_i,
  output logic  q_pop_o,
  output logic  empty,
  input  logic  pop,
  output logic  kind_o,
  output logic  serial_bit_o,
  output logic  common0_level_o,
  output logic  common1_level_o,
  output logic  last_o
);

  logic                  busy_q, busy_d;
  logic [BEAT_CNT_W-1:0] cnt_q, cnt_d;
  tick_t                 cur_q, cur_d;
  logic                  out_valid_q, out_valid_d;
  logic                  kind_q, bit_q, c0_q, c1_q, last_q;
  logic                  kind_d, bit_d, c0_d, c1_d, last_d;

  logic                  advance, have;
  tick_t                 src;
  logic [BEAT_CNT_W-1:0] src_cnt;
  logic [BEAT_CNT_W-1:0] bit_pos;
  logic                  off;

  assign advance = !out_valid_q || pop;
  assign have    = busy_q || q_valid_i;
  assign src     = busy_q ? cur_q : q_data_i;
  assign src_cnt = busy_q ? cnt_q : '0;
  assign q_pop_o = advance && !busy_q && q_valid_i;
  assign off     = common_anode_i;
  assign bit_pos = PAT_MSB_POS - src_cnt;

  // Beat for the current count: blank byte, strobe, digit byte, strobe.
  always_comb begin
    kind_d = 1'b0;
    bit_d  = 1'b0;
    c0_d   = off;
    c1_d   = off;
    last_d = 1'b0;
    if (src_cnt < BLANK_STROBE) begin
      bit_d = common_anode_i;
    end else if (src_cnt == BLANK_STROBE) begin
      kind_d = 1'b1;
    end else begin
      c0_d = src.phase ? off : ~off;
      c1_d = src.phase ? ~off : off;
      if (src_cnt == LAST_BEAT) begin
        kind_d = 1'b1;
        last_d = 1'b1;
      end else if (src_cnt >= PAT_FIRST) begin
        bit_d = src.pattern[bit_pos[2:0]] ^ common_anode_i;
      end
    end
  end

  always_comb begin
    busy_d      = busy_q;
    cnt_d       = cnt_q;
    cur_d       = cur_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = have;
      if (have) begin
        cur_d = src;
        if (src_cnt == LAST_BEAT) begin
          busy_d = 1'b0;
          cnt_d  = '0;
        end else begin
          busy_d = 1'b1;
          cnt_d  = src_cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (advance && have) begin
      kind_q <= kind_d;
      bit_q  <= bit_d;
      c0_q   <= c0_d;
      c1_q   <= c1_d;
      last_q <= last_d;
    end
  end

  assign empty           = !out_valid_q;
  assign kind_o          = kind_q;
  assign serial_bit_o    = bit_q;
  assign common0_level_o = c0_q;
  assign common1_level_o = c1_q;
  assign last_o          = last_q;

endmodule

[rtl/two_digit_seven_segment_serial_driver_core.sv]
// Two-digit multiplexed seven-segment driver for an external 8-bit shift
// register. Set items (decimal, clamped to 99, or hex) store the two digit
// patterns and produce no beats. Each tick produces 18 output beats, one
// per cycle while pop keeps up: 8 blank bits, a latch strobe, the 8 bits
// of the next digit MSB first, and a final strobe flagged by last_o. A
// tick thus occupies the serializer until its last beat is taken; the
// input side keeps taking items until the tick queue (QUEUE_DEPTH entries)
// fills. common_anode inverts the shifted bits and the common levels; it is
// not held per tick, so a write also changes the later beats of a tick.
`include "two_digit_seven_segment_serial_driver_core_macros.svh"

module two_digit_seven_segment_serial_driver_core import ssd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       push,
  output logic       full,
  input  logic [1:0] op_i,
  input  logic [7:0] value_i,
  output logic       empty,
  input  logic       pop,
  output logic       kind_o,
  output logic       serial_bit_o,
  output logic       common0_level_o,
  output logic       common1_level_o,
  output logic       last_o
);

  logic  common_anode_q;
  logic  q_push, q_full, q_valid, q_pop;
  tick_t q_wdata, q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      common_anode_q <= 1'b0;
    end else if (cfg_we_i) begin
      common_anode_q <= cfg_wdata_i;
    end
  end

  ssd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .op_i     (op_i),
    .value_i  (value_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_data_o (q_wdata)
  );

  ssd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (q_rdata)
  );

  ssd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .common_anode_i  (common_anode_q),
    .q_valid_i       (q_valid),
    .q_data_i        (q_rdata),
    .q_pop_o         (q_pop),
    .empty           (empty),
    .pop             (pop),
    .kind_o          (kind_o),
    .serial_bit_o    (serial_bit_o),
    .common0_level_o (common0_level_o),
    .common1_level_o (common1_level_o),
    .last_o          (last_o)
  );

  `SSD_ASSERT_NOW(a_no_overflow, q_push, !q_full, "tick pushed into full queue")
  `SSD_ASSERT_NOW(a_pop_valid, q_pop, q_valid, "serializer loaded from empty queue")
  `SSD_ASSERT_NOW(a_last_strobe, !empty && last_o, kind_o && !serial_bit_o, "last beat not a strobe")
  `SSD_ASSERT_NEXT(a_last_done, !empty && pop && last_o && !q_valid, empty, "beat after last without tick")

endmodule

[tb/tb_two_digit_seven_segment_serial_driver_core.sv]
`timescale 1ns / 100ps

module tb_two_digit_seven_segment_serial_driver_core;
  import ssd_pkg::*;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam logic       KIND_SHIFT   = 1'b0;
  localparam logic       KIND_STROBE  = 1'b1;
  localparam int         IDLE_PCT     = 34;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         SETTLE_CYCLES = 4;
  localparam int         STALL_LIMIT  = 3000;

  // g c d e a b f dp, active high
  localparam logic [7:0] SEG_CODES [16] = '{
    8'h7e, 8'h44, 8'hbc, 8'hec, 8'hc6, 8'hea, 8'hfa, 8'h4c,
    8'hfe, 8'hee, 8'hde, 8'hf2, 8'h3a, 8'hf4, 8'hba, 8'h9a
  };

  typedef struct packed {
    logic kind;
    logic sbit;
    logic c0;
    logic c1;
    logic last;
  } beat_t;

  class seg_beat_board;
    logic        common_anode;
    logic [7:0]  digit_seg [2];
    logic        phase;
    beat_t       due_beats [$];
    int unsigned mismatches;

    function new();
      common_anode = 1'b0;
      digit_seg[0] = 8'h00;
      digit_seg[1] = 8'h00;
      phase        = 1'b0;
      mismatches   = 0;
    endfunction

    function void queue_byte(logic [7:0] pat, logic c0, logic c1, logic last);
      beat_t b;
      for (int i = 7; i >= 0; i--) begin
        b = '{kind: KIND_SHIFT, sbit: pat[i], c0: c0, c1: c1, last: 1'b0};
        due_beats.push_back(b);
      end
      b = '{kind: KIND_STROBE, sbit: 1'b0, c0: c0, c1: c1, last: last};
      due_beats.push_back(b);
    endfunction

    function void note_item(logic [1:0] op, logic [7:0] val);
      int unsigned v;
      logic [7:0]  inv;
      logic        off;
      logic        on;
      v   = val;
      inv = common_anode ? 8'hff : 8'h00;
      off = common_anode;
      on  = ~common_anode;
      case (op)
        OP_SET_DEC: begin
          if (v > 99) v = 99;
          digit_seg[0] = SEG_CODES[v % 10];
          digit_seg[1] = SEG_CODES[v / 10];
        end
        OP_SET_HEX: begin
          digit_seg[0] = SEG_CODES[val[3:0]];
          digit_seg[1] = SEG_CODES[val[7:4]];
        end
        OP_TICK: begin
          queue_byte(8'h00 ^ inv, off, off, 1'b0);
          phase = ~phase;
          if (phase) queue_byte(digit_seg[1] ^ inv, off, on, 1'b1);
          else queue_byte(digit_seg[0] ^ inv, on, off, 1'b1);
        end
        default: ;
      endcase
    endfunction

    function void check_beat(beat_t got);
      beat_t want;
      if (due_beats.size() == 0) begin
        $error("beat with nothing pending: kind %0d bit %0d", got.kind, got.sbit);
        mismatches++;
        return;
      end
      want = due_beats.pop_front();
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
        mismatches++;
      end
      if (got.sbit !== want.sbit) begin
        $error("serial_bit: expected %0d, got %0d", want.sbit, got.sbit);
        mismatches++;
      end
      if (got.c0 !== want.c0) begin
        $error("common0_level: expected %0d, got %0d", want.c0, got.c0);
        mismatches++;
      end
      if (got.c1 !== want.c1) begin
        $error("common1_level: expected %0d, got %0d", want.c1, got.c1);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic       cfg_wdata_i;
  logic       push;
  logic       full;
  logic [1:0] op_i;
  logic [7:0] value_i;
  logic       empty;
  logic       pop;
  logic       kind_o;
  logic       serial_bit_o;
  logic       common0_level_o;
  logic       common1_level_o;
  logic       last_o;

  logic steady = 1'b0;
  logic hold_req = 1'b0;
  int   hold_left = 0;

  seg_beat_board board = new();

  two_digit_seven_segment_serial_driver_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .push           (push),
    .full           (full),
    .op_i           (op_i),
    .value_i        (value_i),
    .empty          (empty),
    .pop            (pop),
    .kind_o         (kind_o),
    .serial_bit_o   (serial_bit_o),
    .common0_level_o(common0_level_o),
    .common1_level_o(common1_level_o),
    .last_o         (last_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // result side
  initial begin
    pop = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        if (pop && !empty)
          board.check_beat('{kind: kind_o, sbit: serial_bit_o, c0: common0_level_o,
                             c1: common1_level_o, last: last_o});
        if (hold_req) begin
          hold_left = HOLD_CYCLES;
          hold_req <= 1'b0;
        end
        if (hold_left > 0) begin
          hold_left--;
          pop <= 1'b0;
        end else begin
          pop <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
      end
    end
  end

  // watchdog on cycles without any accepted item or beat
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty) || !rst_ni) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("tb_two_digit_seven_segment_serial_driver_core: errors");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [7:0] val);
    while (!steady && ($urandom_range(99) < IDLE_PCT)) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push    <= 1'b1;
    op_i    <= op;
    value_i <= val;
    do @(posedge clk_i); while (full);
    board.note_item(op, val);
  endtask

  task automatic write_polarity(input logic ca);
    push <= 1'b0;
    while (board.due_beats.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= ca;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.common_anode = ca;
  endtask

  task automatic send_random(input int count);
    int r;
    logic [7:0] v;
    send_item(OP_TICK, 8'($urandom));
    for (int n = 1; n < count; n++) begin
      r = $urandom_range(99);
      v = 8'($urandom);
      if (r < 45) send_item(OP_TICK, v);
      else if (r < 70) send_item(OP_SET_DEC, r[0] ? 8'($urandom_range(99)) : v);
      else if (r < 93) send_item(OP_SET_HEX, v);
      else send_item(OP_UNUSED, v);
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    push        = 1'b0;
    op_i        = OP_TICK;
    value_i     = 8'h00;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // blank digits right after reset, digit one first
    send_item(OP_TICK, 8'hff);
    send_item(OP_TICK, 8'h00);
    send_item(OP_SET_DEC, 8'd0);
    send_item(OP_TICK, 8'h00);
    send_item(OP_TICK, 8'h00);
    send_item(OP_SET_DEC, 8'd99);
    send_item(OP_TICK, 8'h00);
    send_item(OP_SET_DEC, 8'd100);
    send_item(OP_TICK, 8'h00);
    send_item(OP_SET_DEC, 8'd255);
    send_item(OP_TICK, 8'h00);
    send_item(OP_SET_HEX, 8'h00);
    send_item(OP_TICK, 8'h00);
    send_item(OP_SET_HEX, 8'hff);
    send_item(OP_TICK, 8'h00);
    send_item(OP_TICK, 8'h00);
    send_item(OP_SET_HEX, 8'h5a);
    send_item(OP_UNUSED, 8'hff);
    send_item(OP_TICK, 8'h00);
    send_item(OP_UNUSED, 8'h00);
    send_item(OP_SET_DEC, 8'd47);
    send_item(OP_TICK, 8'h00);
    send_item(OP_TICK, 8'h00);

    // polarity flips without a fresh set
    write_polarity(1'b1);
    steady <= 1'b1;
    send_random(75);
    write_polarity(1'b0);
    steady   <= 1'b0;
    hold_req <= 1'b1;
    send_random(75);
    write_polarity(1'b1);
    send_random(75);
    write_polarity(1'b0);
    send_random(75);
    push <= 1'b0;

    while (board.due_beats.size() != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
    if (board.mismatches == 0 && board.due_beats.size() == 0) begin
      $display("tb_two_digit_seven_segment_serial_driver_core: clean");
    end else begin
      $display("tb_two_digit_seven_segment_serial_driver_core: errors");
    end
    $finish;
  end

endmodule

[two_digit_seven_segment_serial_driver_core.f]
+incdir+rtl
rtl/ssd_pkg.sv
rtl/ssd_front.sv
rtl/ssd_queue.sv
rtl/ssd_back.sv
rtl/two_digit_seven_segment_serial_driver_core.sv
tb/tb_two_digit_seven_segment_serial_driver_core.sv
